/* rtl/button_press_hold_repeat_detector_core_assert.svh */
// Assertion macros used by the checker file
`ifndef BUTTON_PRESS_HOLD_REPEAT_DETECTOR_CORE_ASSERT_SVH
`define BUTTON_PRESS_HOLD_REPEAT_DETECTOR_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define BPHR_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// next-cycle implication, off during reset
`define BPHR_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");

// next-cycle implication, always checked
`define BPHR_ASSERT_NEXT_ALWAYS(label, clk, lhs, rhs) \
   label: assert property (@(posedge clk) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`endif

/* rtl/bphr_pkg.sv */
// Package with shared types, codes and constants of the button detector
package bphr_pkg;

   localparam int NUM_PINS_DEF = 24;

   localparam int PIN_W     = 5;
   localparam int MODE_W    = 2;
   localparam int DUR_W     = 32;
   localparam int CFG_W     = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [MODE_W-1:0] MODE_TICK     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CHANGE   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ASSIGN   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_DEASSIGN = 2'd3;

   localparam logic KIND_PRESS = 1'b0;
   localparam logic KIND_HELD  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HELD     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REPEAT   = 2'd2;

   localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd20;
   localparam logic [CFG_W-1:0] HELD_RST     = 16'd500;
   localparam logic [CFG_W-1:0] REPEAT_RST   = 16'd200;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [PIN_W-1:0]  pin;
      logic              level;
   } req_word_type;

   typedef struct packed {
      logic              valid;
      logic [PIN_W-1:0]  event_pin;
      logic              event_kind;
      logic [DUR_W-1:0]  duration_ms;
      logic              last;
   } res_type;

   typedef struct packed {
      logic [CFG_W-1:0] debounce_ms;
      logic [CFG_W-1:0] held_ms;
      logic [CFG_W-1:0] repeat_ms;
   } cfg_type;

endpackage

/* rtl/bphr_chan_if.sv */
// Valid/ready channel interfaces for request and response words
interface bphr_req_if
   import bphr_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [PIN_W-1:0]  pin;
   logic              level;

   modport source (output valid, output mode, output pin, output level, input ready);
   modport sink (input valid, input mode, input pin, input level, output ready);
endinterface

interface bphr_rsp_if
   import bphr_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [PIN_W-1:0] event_pin;
   logic             event_kind;
   logic [DUR_W-1:0] duration_ms;
   logic             last;

   modport source (output valid, output event_pin, output event_kind,
                   output duration_ms, output last, input ready);
   modport sink (input valid, input event_pin, input event_kind,
                 input duration_ms, input last, output ready);
endinterface

/* rtl/bphr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read
module bphr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 24
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic                                      re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/bphr_engine.sv */
// Sequencer that updates pin flags and the start-time RAM and forms reports
module bphr_engine
   import bphr_pkg::*;
#(
   parameter int NUM_PINS = NUM_PINS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         in_valid,
   output logic         in_ready,
   input  req_word_type in_word,
   input  logic         out_ok,
   output res_type      push
);

   localparam int IDX_W = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
   localparam int CNT_W = $clog2(NUM_PINS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH,
      ST_REL
   } state_type;

   state_type            state_ff, state_in;
   logic [DUR_W-1:0]     now_ff, now_in;
   logic [NUM_PINS-1:0]  pressed_ff, pressed_in;
   logic [NUM_PINS-1:0]  held_ff, held_in;
   logic [NUM_PINS-1:0]  assigned_ff, assigned_in;
   logic [CNT_W-1:0]     rd_cnt_ff, rd_cnt_in;
   logic                 eval_vld_ff, eval_vld_in;
   logic [IDX_W-1:0]     eval_idx_ff, eval_idx_in;
   logic                 pend_vld_ff, pend_vld_in;
   logic [IDX_W-1:0]     pend_idx_ff, pend_idx_in;
   logic [DUR_W-1:0]     pend_dur_ff, pend_dur_in;
   logic [PIN_W-1:0]     rel_pin_ff, rel_pin_in;

   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr;
   logic                 ram_re;
   logic [IDX_W-1:0]     ram_raddr;
   logic [DUR_W-1:0]     ram_rdata;

   logic [IDX_W-1:0]     in_idx;
   logic                 in_range;
   logic [DUR_W-1:0]     elapsed;
   logic                 hit;
   logic                 stall;

   bphr_ram #(
      .WIDTH (DUR_W),
      .DEPTH (NUM_PINS)
   ) u_start_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (now_ff),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign in_idx   = IDX_W'(in_word.pin);
   assign in_range = (32'(in_word.pin) < NUM_PINS);
   assign elapsed  = now_ff - ram_rdata;
   assign in_ready = (state_ff == ST_IDLE) && !reset;

   always_comb begin
      hit = 1'b0;
      if (eval_vld_ff && assigned_ff[eval_idx_ff] && pressed_ff[eval_idx_ff]) begin
         if (held_ff[eval_idx_ff]) begin
            hit = (elapsed >= DUR_W'(cfg.repeat_ms));
         end else begin
            hit = (elapsed >= DUR_W'(cfg.held_ms));
         end
      end
   end

   assign stall = hit && pend_vld_ff && !out_ok;

   always_comb begin
      state_in    = state_ff;
      now_in      = now_ff;
      pressed_in  = pressed_ff;
      held_in     = held_ff;
      assigned_in = assigned_ff;
      rd_cnt_in   = rd_cnt_ff;
      eval_vld_in = eval_vld_ff;
      eval_idx_in = eval_idx_ff;
      pend_vld_in = pend_vld_ff;
      pend_idx_in = pend_idx_ff;
      pend_dur_in = pend_dur_ff;
      rel_pin_in  = rel_pin_ff;
      ram_we      = 1'b0;
      ram_waddr   = eval_idx_ff;
      ram_re      = 1'b0;
      ram_raddr   = rd_cnt_ff[IDX_W-1:0];
      push        = '0;

      case (state_ff)
         ST_IDLE: begin
            if (in_valid && in_ready) begin
               case (in_word.mode)
                  MODE_TICK: begin
                     now_in      = now_ff + DUR_W'(1);
                     rd_cnt_in   = '0;
                     eval_vld_in = 1'b0;
                     pend_vld_in = 1'b0;
                     state_in    = ST_SCAN;
                  end
                  MODE_CHANGE: begin
                     if (in_range && assigned_ff[in_idx]) begin
                        if (!in_word.level) begin
                           ram_we             = 1'b1;
                           ram_waddr          = in_idx;
                           pressed_in[in_idx] = 1'b1;
                        end else begin
                           pressed_in[in_idx] = 1'b0;
                           held_in[in_idx]    = 1'b0;
                           if (pressed_ff[in_idx] && !held_ff[in_idx]) begin
                              ram_re     = 1'b1;
                              ram_raddr  = in_idx;
                              rel_pin_in = in_word.pin;
                              state_in   = ST_REL;
                           end
                        end
                     end
                  end
                  MODE_ASSIGN: begin
                     if (in_range) begin
                        assigned_in[in_idx] = 1'b1;
                        held_in[in_idx]     = 1'b0;
                        pressed_in[in_idx]  = !in_word.level;
                        if (!in_word.level) begin
                           ram_we    = 1'b1;
                           ram_waddr = in_idx;
                        end
                     end
                  end
                  MODE_DEASSIGN: begin
                     if (in_range) begin
                        assigned_in[in_idx] = 1'b0;
                        pressed_in[in_idx]  = 1'b0;
                        held_in[in_idx]     = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (!stall) begin
               if (hit) begin
                  ram_we               = 1'b1;
                  ram_waddr            = eval_idx_ff;
                  held_in[eval_idx_ff] = 1'b1;
                  if (pend_vld_ff) begin
                     push.valid       = 1'b1;
                     push.event_pin   = PIN_W'(pend_idx_ff);
                     push.event_kind  = KIND_HELD;
                     push.duration_ms = pend_dur_ff;
                     push.last        = 1'b0;
                  end
                  pend_vld_in = 1'b1;
                  pend_idx_in = eval_idx_ff;
                  pend_dur_in = elapsed;
               end
               if (rd_cnt_ff < CNT_W'(NUM_PINS)) begin
                  ram_re      = 1'b1;
                  ram_raddr   = rd_cnt_ff[IDX_W-1:0];
                  eval_idx_in = rd_cnt_ff[IDX_W-1:0];
                  eval_vld_in = 1'b1;
                  rd_cnt_in   = rd_cnt_ff + CNT_W'(1);
               end else begin
                  eval_vld_in = 1'b0;
                  state_in    = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_vld_ff) begin
               state_in = ST_IDLE;
            end else if (out_ok) begin
               push.valid       = 1'b1;
               push.event_pin   = PIN_W'(pend_idx_ff);
               push.event_kind  = KIND_HELD;
               push.duration_ms = pend_dur_ff;
               push.last        = 1'b1;
               pend_vld_in      = 1'b0;
               state_in         = ST_IDLE;
            end
         end
         ST_REL: begin
            if (elapsed < DUR_W'(cfg.debounce_ms)) begin
               state_in = ST_IDLE;
            end else if (out_ok) begin
               push.valid       = 1'b1;
               push.event_pin   = rel_pin_ff;
               push.event_kind  = KIND_PRESS;
               push.duration_ms = elapsed;
               push.last        = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         now_ff      <= '0;
         pressed_ff  <= '0;
         held_ff     <= '0;
         assigned_ff <= '0;
         rd_cnt_ff   <= '0;
         eval_vld_ff <= 1'b0;
         pend_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         now_ff      <= now_in;
         pressed_ff  <= pressed_in;
         held_ff     <= held_in;
         assigned_ff <= assigned_in;
         rd_cnt_ff   <= rd_cnt_in;
         eval_vld_ff <= eval_vld_in;
         pend_vld_ff <= pend_vld_in;
      end
      eval_idx_ff <= eval_idx_in;
      pend_idx_ff <= pend_idx_in;
      pend_dur_ff <= pend_dur_in;
      rel_pin_ff  <= rel_pin_in;
   end

endmodule

/* rtl/button_press_hold_repeat_detector_core.sv */
// Top level of the button press, hold and auto-repeat detector
//
// Usage:
//   req_chan carries one word per item: mode (tick, level change, assign,
//   deassign), pin and level. rsp_chan returns report words: event_pin,
//   event_kind (single press or held), duration_ms and last, which marks
//   the final report caused by one request word.
//   csr_we/csr_index/csr_wdata write debounce_ms (0), held_ms (1) and
//   repeat_ms (2); write them only while the block is idle.
// Sequencing:
//   Assign, deassign, press and release-of-idle-or-held-pin words stay in idle.
//   A release of a pressed, unheld pin reads its start time in the release
//   state and reports a press of at least debounce_ms once the output is free.
//   A tick steps the clock and reads the start-time RAM one pin entry per
//   cycle unless stalled, then pushes the pending held report, if any.
//   Each held report of a tick waits in a pending slot until the next
//   reporting pin is found or the scan ends, so the final one carries last.
//   A stalled response holds its word in the output register; the scan
//   stops while the next report cannot be handed over.
// Reset:
//   Clears the clock, all pin flags and the output valid flag and restores
//   the register defaults (20, 500, 200). No RAM clearing pass is needed.
module button_press_hold_repeat_detector_core
   import bphr_pkg::*;
#(
   parameter int NUM_PINS = NUM_PINS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   bphr_req_if.sink             req_chan,
   bphr_rsp_if.source           rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   cfg_type          cfg_ff;
   req_word_type     in_word;
   res_type          push;
   logic             out_ok;
   logic             rsp_valid_ff;
   logic [PIN_W-1:0] rsp_pin_ff;
   logic             rsp_kind_ff;
   logic [DUR_W-1:0] rsp_dur_ff;
   logic             rsp_last_ff;

   assign in_word.mode  = req_chan.mode;
   assign in_word.pin   = req_chan.pin;
   assign in_word.level = req_chan.level;

   bphr_engine #(
      .NUM_PINS (NUM_PINS)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (req_chan.valid),
      .in_ready (req_chan.ready),
      .in_word  (in_word),
      .out_ok   (out_ok),
      .push     (push)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms <= DEBOUNCE_RST;
         cfg_ff.held_ms     <= HELD_RST;
         cfg_ff.repeat_ms   <= REPEAT_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_DEBOUNCE: cfg_ff.debounce_ms <= csr_wdata;
            REG_HELD:     cfg_ff.held_ms     <= csr_wdata;
            REG_REPEAT:   cfg_ff.repeat_ms   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign out_ok = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (push.valid) begin
         rsp_pin_ff  <= push.event_pin;
         rsp_kind_ff <= push.event_kind;
         rsp_dur_ff  <= push.duration_ms;
         rsp_last_ff <= push.last;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.event_pin   = rsp_pin_ff;
   assign rsp_chan.event_kind  = rsp_kind_ff;
   assign rsp_chan.duration_ms = rsp_dur_ff;
   assign rsp_chan.last        = rsp_last_ff;

endmodule

/* rtl/bphr_checker.sv */
// Port-level checker for the button detector and its bind
`include "button_press_hold_repeat_detector_core_assert.svh"

module bphr_checker
   import bphr_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [MODE_W-1:0] req_mode,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [PIN_W-1:0]  rsp_event_pin,
   input logic              rsp_event_kind,
   input logic [DUR_W-1:0]  rsp_duration_ms,
   input logic              rsp_last
);

   `BPHR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_event_pin) && $stable(rsp_duration_ms) && $stable(rsp_last))
   `BPHR_ASSERT_NEXT(a_tick_busy, clock, reset, req_valid && req_ready && (req_mode == MODE_TICK), !req_ready)
   `BPHR_ASSERT_IMPLY(a_press_last, clock, reset, rsp_valid && (rsp_event_kind == KIND_PRESS), rsp_last)
   `BPHR_ASSERT_NEXT_ALWAYS(a_reset_idle, clock, reset, !rsp_valid)

endmodule

bind button_press_hold_repeat_detector_core bphr_checker u_bphr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .req_mode        (req_chan.mode),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_event_pin   (rsp_chan.event_pin),
   .rsp_event_kind  (rsp_chan.event_kind),
   .rsp_duration_ms (rsp_chan.duration_ms),
   .rsp_last        (rsp_chan.last)
);
